// ----- hw/rtl/llfs_pkg.sv -----
// llfs_pkg: shared types and constants of the log line field splitter
// holds field tags, character codes, phase and dash tracker enums, control struct
// no dependencies
`default_nettype none

package llfs_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TAG_W  = 3;
  localparam int unsigned ACC_W  = 32;

  // output stream word: tag, byte, line_ok, status, count, padded to bytes
  localparam int unsigned OUT_BITS   = TAG_W + BYTE_W + 1 + ACC_W + ACC_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [TAG_W-1:0]  field_tag_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ACC_W-1:0]  acc_t;

  // field tags
  localparam field_tag_t TAG_HOST    = 3'd0;
  localparam field_tag_t TAG_IDENT   = 3'd1;
  localparam field_tag_t TAG_USER    = 3'd2;
  localparam field_tag_t TAG_DATE    = 3'd3;
  localparam field_tag_t TAG_REQUEST = 3'd4;
  localparam field_tag_t TAG_STATUS  = 3'd5;
  localparam field_tag_t TAG_COUNT   = 3'd6;
  localparam field_tag_t TAG_DELIM   = 3'd7;

  // character codes
  localparam byte_t CH_SPACE    = 8'h20;
  localparam byte_t CH_QUOTE    = 8'h22;
  localparam byte_t CH_DASH     = 8'h2D;
  localparam byte_t CH_ZERO     = 8'h30;
  localparam byte_t CH_RBRACKET = 8'h5D;

  // skip lengths ahead of date, request and status
  localparam logic [1:0] SKIP_ONE = 2'd1;
  localparam logic [1:0] SKIP_TWO = 2'd2;

  // parser phase
  typedef enum logic [3:0] {
    PH_HOST        = 4'd0,
    PH_IDENT       = 4'd1,
    PH_USER        = 4'd2,
    PH_SKIP_DATE   = 4'd3,
    PH_DATE        = 4'd4,
    PH_SKIP_REQ    = 4'd5,
    PH_REQUEST     = 4'd6,
    PH_SKIP_STATUS = 4'd7,
    PH_STATUS      = 4'd8,
    PH_COUNT       = 4'd9
  } phase_t;

  // content of a number field so far
  typedef enum logic [1:0] {
    DASH_EMPTY = 2'd0,
    DASH_ONLY  = 2'd1,
    DASH_OTHER = 2'd2
  } dash_t;

  // per-byte control from the phase tracker to the accumulators
  typedef struct packed {
    field_tag_t tag;
    logic       status_digit;
    logic       count_digit;
    logic       count_reached;
  } llfs_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/llfs_phase.sv -----
// llfs_phase: phase tracker that tags each byte with its field
// depends on llfs_pkg
`default_nettype none

module llfs_phase
  import llfs_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        step,
  input  byte_t      data_byte,
  input  wire        line_end,
  output llfs_ctrl_t ctrl
);

  phase_t     phase;
  phase_t     phase_next;
  logic [1:0] skip_left;
  logic [1:0] skip_left_next;

  // next phase and skip count
  always_comb begin
    phase_next     = phase;
    skip_left_next = skip_left;
    unique case (phase)
      PH_HOST: begin
        if (data_byte == CH_SPACE) phase_next = PH_IDENT;
      end
      PH_IDENT: begin
        if (data_byte == CH_SPACE) phase_next = PH_USER;
      end
      PH_USER: begin
        if (data_byte == CH_SPACE) begin
          phase_next     = PH_SKIP_DATE;
          skip_left_next = SKIP_ONE;
        end
      end
      PH_DATE: begin
        if (data_byte == CH_RBRACKET) begin
          phase_next     = PH_SKIP_REQ;
          skip_left_next = SKIP_TWO;
        end
      end
      PH_REQUEST: begin
        if (data_byte == CH_QUOTE) begin
          phase_next     = PH_SKIP_STATUS;
          skip_left_next = SKIP_ONE;
        end
      end
      PH_STATUS: begin
        if (data_byte == CH_SPACE) phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        phase_next = PH_COUNT;
      end
      PH_SKIP_DATE, PH_SKIP_REQ, PH_SKIP_STATUS: begin
        if (skip_left > SKIP_ONE) begin
          skip_left_next = skip_left - SKIP_ONE;
        end else begin
          skip_left_next = '0;
          if (phase == PH_SKIP_DATE) phase_next = PH_DATE;
          else if (phase == PH_SKIP_REQ) phase_next = PH_REQUEST;
          else phase_next = PH_STATUS;
        end
      end
      default: begin
        phase_next = PH_HOST;
      end
    endcase
  end

  // tag and digit strobes for the current byte
  always_comb begin
    ctrl               = '0;
    ctrl.tag           = TAG_DELIM;
    ctrl.count_reached = (phase_next == PH_COUNT);
    unique case (phase)
      PH_HOST:    if (data_byte != CH_SPACE) ctrl.tag = TAG_HOST;
      PH_IDENT:   if (data_byte != CH_SPACE) ctrl.tag = TAG_IDENT;
      PH_USER:    if (data_byte != CH_SPACE) ctrl.tag = TAG_USER;
      PH_DATE:    if (data_byte != CH_RBRACKET) ctrl.tag = TAG_DATE;
      PH_REQUEST: if (data_byte != CH_QUOTE) ctrl.tag = TAG_REQUEST;
      PH_STATUS: begin
        if (data_byte != CH_SPACE) begin
          ctrl.tag          = TAG_STATUS;
          ctrl.status_digit = 1'b1;
        end
      end
      PH_COUNT: begin
        ctrl.tag         = TAG_COUNT;
        ctrl.count_digit = 1'b1;
      end
      default: ctrl.tag = TAG_DELIM;
    endcase
  end

  // state register, back to line start after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HOST;
      skip_left <= '0;
    end else if (step) begin
      if (line_end) begin
        phase     <= PH_HOST;
        skip_left <= '0;
      end else begin
        phase     <= phase_next;
        skip_left <= skip_left_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/llfs_acc.sv -----
// llfs_acc: decimal accumulator with dash-only tracking for one number field
// depends on llfs_pkg
`default_nettype none

module llfs_acc
  import llfs_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   step,
  input  wire   digit_en,
  input  wire   line_end,
  input  byte_t data_byte,
  output acc_t  acc_upd,
  output logic  dash_only
);

  acc_t  acc;
  dash_t track;
  dash_t track_upd;

  // value*10 + (byte - '0'), wrapping
  always_comb begin
    acc_upd   = acc;
    track_upd = track;
    if (digit_en) begin
      acc_upd = (acc << 3) + (acc << 1) + {{(ACC_W-BYTE_W){1'b0}}, data_byte}
                - {{(ACC_W-BYTE_W){1'b0}}, CH_ZERO};
      track_upd = (track == DASH_EMPTY && data_byte == CH_DASH) ? DASH_ONLY : DASH_OTHER;
    end
  end

  assign dash_only = (track_upd == DASH_ONLY);

  // field state, cleared at the end of each line
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      track <= DASH_EMPTY;
    end else if (step) begin
      if (line_end) begin
        acc   <= '0;
        track <= DASH_EMPTY;
      end else begin
        acc   <= acc_upd;
        track <= track_upd;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/log_line_field_splitter.sv -----
// log_line_field_splitter: top level of the common log format byte tagger
// depends on llfs_pkg, llfs_phase, llfs_acc
`default_nettype none

// Takes one log line byte per request and returns one result per byte, tagging it
// as host, ident, user, date, request, status, byte count or delimiter. On the last
// byte (tlast) the result carries line_ok and, if it is set, the decimal status and byte count.
// Throughput is one byte per cycle while m_tready does not stall the result; each
// byte passes through the input register and then the result register. The phase
// tracker and both accumulators update once per byte from the input register, so
// a byte's result depends only on it and the earlier bytes of the same line.
module log_line_field_splitter
  import llfs_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  input  wire  [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  wire                   s_tlast,   // line_end
  output logic                  m_tvalid,
  input  wire                   m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] field_tag, [10:3] byte_echo,
                                           // [11] line_ok, [43:12] status_value,
                                           // [75:44] count_value, [79:76] zero
  output logic                  m_tlast    // is_last
);

  logic       in_valid;
  byte_t      in_byte;
  logic       in_last;
  logic       in_step;
  logic       out_free;
  llfs_ctrl_t ctrl;
  acc_t       status_upd;
  acc_t       count_upd;
  logic       status_dash;
  logic       count_dash;
  logic       line_ok;

  field_tag_t out_tag;
  byte_t      out_byte;
  logic       out_ok;
  acc_t       out_status;
  acc_t       out_count;

  // handshake between the two register stages
  assign out_free = !m_tvalid || m_tready;
  assign in_step  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  llfs_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .step      (in_step),
    .data_byte (in_byte),
    .line_end  (in_last),
    .ctrl      (ctrl)
  );

  llfs_acc u_status (
    .clk       (clk),
    .rst       (rst),
    .step      (in_step),
    .digit_en  (ctrl.status_digit),
    .line_end  (in_last),
    .data_byte (in_byte),
    .acc_upd   (status_upd),
    .dash_only (status_dash)
  );

  llfs_acc u_count (
    .clk       (clk),
    .rst       (rst),
    .step      (in_step),
    .digit_en  (ctrl.count_digit),
    .line_end  (in_last),
    .data_byte (in_byte),
    .acc_upd   (count_upd),
    .dash_only (count_dash)
  );

  // line verdict on the last byte
  assign line_ok = in_last && ctrl.count_reached && !status_dash && !count_dash;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_step) begin
      out_tag    <= ctrl.tag;
      out_byte   <= in_byte;
      m_tlast    <= in_last;
      out_ok     <= line_ok;
      out_status <= line_ok ? status_upd : '0;
      out_count  <= line_ok ? count_upd : '0;
    end
  end

  // pack the result word
  always_comb begin
    m_tdata = '0;
    m_tdata[OUT_BITS-1:0] = {out_count, out_status, out_ok, out_byte, out_tag};
  end

endmodule

`default_nettype wire

// ----- hw/rtl/llfs_checker.sv -----
// llfs_checker: port-level checks for log_line_field_splitter, bound to the top
// depends on llfs_pkg
`default_nettype none

module llfs_checker
  import llfs_pkg::*;
(
  input wire                  clk,
  input wire                  rst,
  input wire                  m_tvalid,
  input wire                  m_tready,
  input wire [OUT_DATA_W-1:0] m_tdata,
  input wire                  m_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // verdict and numbers only on the last byte of a line
  a_mid_line_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[OUT_BITS-1:TAG_W+BYTE_W] == '0)
    else $error("verdict fields set before line end");

  // a rejected line reports zero status and count
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[TAG_W+BYTE_W] |-> m_tdata[OUT_BITS-1:TAG_W+BYTE_W+1] == '0)
    else $error("rejected line carries numbers");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind log_line_field_splitter llfs_checker u_llfs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: self-checking stream test of log_line_field_splitter
// keeps its own byte-by-byte model of the line parser and checks every result
// depends on llfs_pkg and log_line_field_splitter
`default_nettype none

module testbench
  import llfs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam acc_t DEC_BASE = 32'd10;

  // one byte request as it goes to the block
  typedef struct packed {
    byte_t data;
    logic  last;
  } line_byte_t;

  // one result as the block should return it
  typedef struct packed {
    field_tag_t tag;
    byte_t      echo;
    logic       last;
    logic       ok;
    acc_t       status;
    acc_t       count;
  } byte_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  line_byte_t   line_bytes[$];
  byte_result_t expected_results[$];
  bit           holding = 1'b0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  mismatches = 0;
  int unsigned  bytes_in = 0;
  int unsigned  lines_ok = 0;
  int unsigned  lines_bad = 0;

  // parser state of the model
  phase_t     ph = PH_HOST;
  logic [1:0] skips = '0;
  acc_t       st_acc = '0;
  acc_t       ct_acc = '0;
  dash_t      st_dash = DASH_EMPTY;
  dash_t      ct_dash = DASH_EMPTY;

  log_line_field_splitter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic void clear_line();
    ph      = PH_HOST;
    skips   = '0;
    st_acc  = '0;
    ct_acc  = '0;
    st_dash = DASH_EMPTY;
    ct_dash = DASH_EMPTY;
  endfunction

  function automatic acc_t next_decimal(input acc_t acc, input byte_t b);
    return acc * DEC_BASE + acc_t'(b) - acc_t'(CH_ZERO);
  endfunction

  function automatic dash_t next_dash(input dash_t d, input byte_t b);
    return (d == DASH_EMPTY && b == CH_DASH) ? DASH_ONLY : DASH_OTHER;
  endfunction

  // tag one byte, advance the line state and judge the line on its last byte
  function automatic byte_result_t split_byte(input byte_t b, input logic last);
    byte_result_t r;
    r      = '0;
    r.tag  = TAG_DELIM;
    r.echo = b;
    r.last = last;
    case (ph)
      PH_HOST, PH_IDENT, PH_USER: begin
        if (b == CH_SPACE) begin
          if (ph == PH_USER) begin
            ph    = PH_SKIP_DATE;
            skips = SKIP_ONE;
          end else if (ph == PH_HOST) begin
            ph = PH_IDENT;
          end else begin
            ph = PH_USER;
          end
        end else if (ph == PH_HOST) begin
          r.tag = TAG_HOST;
        end else if (ph == PH_IDENT) begin
          r.tag = TAG_IDENT;
        end else begin
          r.tag = TAG_USER;
        end
      end
      PH_DATE: begin
        if (b == CH_RBRACKET) begin
          ph    = PH_SKIP_REQ;
          skips = SKIP_TWO;
        end else begin
          r.tag = TAG_DATE;
        end
      end
      PH_REQUEST: begin
        if (b == CH_QUOTE) begin
          ph    = PH_SKIP_STATUS;
          skips = SKIP_ONE;
        end else begin
          r.tag = TAG_REQUEST;
        end
      end
      PH_STATUS: begin
        if (b == CH_SPACE) begin
          ph = PH_COUNT;
        end else begin
          r.tag   = TAG_STATUS;
          st_acc  = next_decimal(st_acc, b);
          st_dash = next_dash(st_dash, b);
        end
      end
      PH_COUNT: begin
        r.tag   = TAG_COUNT;
        ct_acc  = next_decimal(ct_acc, b);
        ct_dash = next_dash(ct_dash, b);
      end
      // skipped bytes, value ignored
      default: begin
        if (skips > SKIP_ONE) begin
          skips = skips - 2'd1;
        end else begin
          skips = '0;
          if (ph == PH_SKIP_DATE) ph = PH_DATE;
          else if (ph == PH_SKIP_REQ) ph = PH_REQUEST;
          else ph = PH_STATUS;
        end
      end
    endcase
    if (last) begin
      if (ph == PH_COUNT && st_dash != DASH_ONLY && ct_dash != DASH_ONLY) begin
        r.ok     = 1'b1;
        r.status = st_acc;
        r.count  = ct_acc;
        lines_ok++;
      end else begin
        lines_bad++;
      end
      clear_line();
    end
    return r;
  endfunction

  // request driver: predicts on acceptance, then offers the next byte or idles
  always @(posedge clk) begin : drive_requests
    line_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      holding = 1'b0;
      clear_line();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(split_byte(s_tdata, s_tlast));
        bytes_in++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = line_bytes.pop_front();
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.last;
          s_tvalid <= 1'b1;
          holding = 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    byte_result_t want;
    byte_result_t got;
    logic [3:0]   pad;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.tag    = m_tdata[2:0];
        got.echo   = m_tdata[10:3];
        got.ok     = m_tdata[11];
        got.status = m_tdata[43:12];
        got.count  = m_tdata[75:44];
        got.last   = m_tlast;
        pad        = m_tdata[79:76];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: tag %0d byte %h last %b", got.tag, got.echo,
                     got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || pad !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at byte result %0d:", bytes_in);
              $display("  expected tag %0d byte %h last %b ok %b status %0d count %0d",
                       want.tag, want.echo, want.last, want.ok, $signed(want.status),
                       $signed(want.count));
              $display("  actual   tag %0d byte %h last %b ok %b status %0d count %0d pad %h",
                       got.tag, got.echo, got.last, got.ok, $signed(got.status),
                       $signed(got.count), pad);
            end
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++)
      line_bytes.push_back(line_byte_t'{s[i], (i == s.len() - 1)});
  endtask

  // random bytes other than the field's delimiter, up to max_len of them
  task automatic add_field(ref byte_t txt[$], input byte_t stop, input int unsigned max_len);
    int unsigned n;
    byte_t       b;
    n = $urandom_range(max_len);
    repeat (n) begin
      do b = byte_t'($urandom_range(255)); while (b == stop);
      txt.push_back(b);
    end
  endtask

  task automatic add_digits(ref byte_t txt[$], input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(hi, lo)) txt.push_back(CH_ZERO + byte_t'($urandom_range(9)));
  endtask

  // one line: mostly well formed, some cut short, some plain noise
  task automatic queue_line();
    byte_t       txt[$];
    int unsigned kind;
    int unsigned pick;
    int unsigned cut;
    kind = $urandom_range(99);
    if (kind < 12) begin
      add_field(txt, CH_SPACE, 0);
      repeat ($urandom_range(20, 1)) txt.push_back(byte_t'($urandom_range(255)));
    end else begin
      add_field(txt, CH_SPACE, 4);
      txt.push_back(CH_SPACE);
      add_field(txt, CH_SPACE, 2);
      txt.push_back(CH_SPACE);
      add_field(txt, CH_SPACE, 3);
      txt.push_back(CH_SPACE);
      txt.push_back(byte_t'($urandom_range(255)));
      add_field(txt, CH_RBRACKET, 6);
      txt.push_back(CH_RBRACKET);
      txt.push_back(byte_t'($urandom_range(255)));
      txt.push_back(byte_t'($urandom_range(255)));
      add_field(txt, CH_QUOTE, 8);
      txt.push_back(CH_QUOTE);
      txt.push_back(byte_t'($urandom_range(255)));
      // status: digits, a lone dash, a dash and digits, junk or nothing
      pick = $urandom_range(9);
      if (pick == 1) begin
        txt.push_back(CH_DASH);
      end else if (pick == 2) begin
        add_field(txt, CH_SPACE, 4);
      end else if (pick == 3) begin
        txt.push_back(CH_DASH);
        add_digits(txt, 1, 3);
      end else if (pick != 0) begin
        add_digits(txt, 1, 3);
      end
      txt.push_back(CH_SPACE);
      // byte count: runs to the end, empty when the status space is last
      pick = $urandom_range(9);
      if (pick == 1) begin
        txt.push_back(CH_DASH);
      end else if (pick == 2) begin
        repeat ($urandom_range(5, 1)) txt.push_back(byte_t'($urandom_range(255)));
      end else if (pick == 3) begin
        add_digits(txt, 10, 14);
      end else if (pick == 4) begin
        txt.push_back(CH_DASH);
        add_digits(txt, 1, 2);
      end else if (pick != 0) begin
        add_digits(txt, 1, 6);
      end
      if (kind < 27) begin
        cut = $urandom_range(txt.size(), 1);
        txt = txt[0:cut-1];
      end
    end
    foreach (txt[i]) line_bytes.push_back(line_byte_t'{txt[i], (i == txt.size() - 1)});
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned target);
    int unsigned queued;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queued = 0;
    while (queued < target) begin
      cut_free: begin
        int unsigned was;
        was = line_bytes.size();
        queue_line();
        queued += line_bytes.size() - was;
      end
    end
    while (line_bytes.size() != 0 || holding || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 19;
    recv_idle_pct = 56;
    // empty fields everywhere, line ends at the status space
    queue_text("   [] \"\"  ");
    // status that is a lone dash
    queue_text("a   [] \"\" - 5");
    // one-byte lines at both byte extremes, ended before any delimiter
    line_bytes.push_back(line_byte_t'{8'h00, 1'b1});
    line_bytes.push_back(line_byte_t'{8'hFF, 1'b1});
    run_phase(19, 56, 430);
    run_phase(56, 19, 430);
    run_phase(0, 0, 430);
    repeat (8) @(posedge clk);
    $display("checked %0d bytes in %0d lines: %0d accepted, %0d rejected",
             bytes_in, lines_ok + lines_bad, lines_ok, lines_bad);
    if (mismatches == 0) begin
      $display("log_line_field_splitter test passed");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("log_line_field_splitter test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("log_line_field_splitter test failed");
    $finish;
  end

endmodule

`default_nettype wire
